// File: src/blf_pkg.sv
// Shared constants, types and tables of the bilateral luma filter.
package blf_pkg;

    localparam int MAX_RADIUS  = 10;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WEIGHT_BITS = 16;

    localparam int LS_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int SW_DEPTH = 2 * MAX_RADIUS * MAX_RADIUS + 1;
    localparam int LS_DEPTH = LS_ROWS * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int SW_AW    = $clog2(SW_DEPTH);
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int RMOD_W   = $clog2(LS_ROWS);
    localparam int DXY_W    = $clog2(MAX_RADIUS + 1);
    localparam int WID_W    = 12;
    localparam int HGT_W    = 13;
    localparam int RAD_W    = 4;
    localparam int CFG_DW   = 13;
    localparam int LUMA_W   = 16;
    localparam int NUM_W    = 42;
    localparam int NORM_W   = 26;
    localparam int DIV_STEPS = LUMA_W;
    localparam int DIVC_W   = $clog2(DIV_STEPS);
    localparam int BT601_LIMIT = 800;

    typedef enum logic [1:0] {
        FUNC_PIXEL = 2'd0,
        FUNC_DRAIN = 2'd1,
        FUNC_LOAD  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_FORMAT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_RADIUS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                 wr_en;
        logic [LS_AW-1:0]     wr_addr;
        logic                 sw_wr;
        logic                 rd_en;
        logic                 rd_ref;
        logic [LS_AW-1:0]     rd_addr;
        logic [SW_AW-1:0]     rd_si;
        logic                 div_load;
        logic                 div_step;
        logic                 conv;
        logic                 out_load;
        logic                 last;
        logic                 fmt;
        logic                 msel;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_stat;

    typedef logic [255:0][WEIGHT_BITS-1:0] t_rng_rom;

    // Range weights exp(-(d/255)^2/0.02) built by the same fixed point recurrence
    // that defines them, evaluated once at elaboration.
    function automatic t_rng_rom f_range_rom();
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] q2;
        logic [63:0] v;
        t_rng_rom    rom;
        e  = 64'h1_0000_0000;
        m  = 64'd4291666015;
        q2 = (m * m) >> 32;
        for (int d = 0; d < 256; d++) begin
            if (d > 0) begin
                e = (e * m) >> 32;
                m = (m * q2) >> 32;
            end
            v = (e + (64'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
            rom[d] = (v > 64'((1 << WEIGHT_BITS) - 1)) ? {WEIGHT_BITS{1'b1}}
                                                      : v[WEIGHT_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

// File: src/blf_in_if.sv
// Input item channel of the bilateral luma filter.
interface blf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] pixel_word;
    logic [7:0]  weight_index;
    logic [15:0] weight_value;

    modport source (output valid, func, pixel_word, weight_index, weight_value,
                    input ready);
    modport sink   (input valid, func, pixel_word, weight_index, weight_value,
                    output ready);
endinterface

// File: src/blf_out_if.sv
// Result item channel of the bilateral luma filter.
interface blf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic        last_in_frame;
    logic        zero_normaliser;

    modport source (output valid, out_pixel, last_in_frame, zero_normaliser,
                    input ready);
    modport sink   (input valid, out_pixel, last_in_frame, zero_normaliser,
                    output ready);
endinterface

// File: src/blf_cfg_if.sv
// Configuration write channel of the bilateral luma filter.
interface blf_cfg_if;
    logic                 valid;
    logic                 ready;
    blf_pkg::t_cfg_idx    index;
    logic [blf_pkg::CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/blf_ctrl.sv
// Controller: registers, raster counters and the window sequencer.
module blf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  blf_pkg::t_func              i_func,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  blf_pkg::t_cfg_idx           i_cfg_index,
    input  logic [blf_pkg::CFG_DW-1:0]  i_cfg_data,
    input  blf_pkg::t_stat              i_stat,
    output blf_pkg::t_cmd               o_cmd
);
    import blf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_REF   = 8'b0000_0100,
        S_TAPS  = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_CONV  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic                r_fmt, n_fmt;
    logic [WID_W-1:0]    r_width, n_width;
    logic [HGT_W-1:0]    r_height, n_height;
    logic [RAD_W-1:0]    r_radius, n_radius;
    logic [COL_W-1:0]    r_icol, n_icol, r_ocol, n_ocol;
    logic [ROW_W-1:0]    r_irow, n_irow, r_orow, n_orow;
    logic [RMOD_W-1:0]   r_irmod, n_irmod, r_ormod, n_ormod;
    logic                r_ahead, n_ahead;
    logic [COL_W-1:0]    r_x, n_x, r_x0, n_x0, r_nc, n_nc;
    logic [ROW_W-1:0]    r_y, n_y, r_nr, n_nr;
    logic [RMOD_W-1:0]   r_ymod, n_ymod;
    logic [DIVC_W-1:0]   r_dcnt, n_dcnt;

    logic [WID_W-1:0]    w_eff, w_m1, nc_sum;
    logic [HGT_W-1:0]    h_eff, h_m1, nr_sum;
    logic [RAD_W-1:0]    rad_eff;
    logic [ROW_W-1:0]    nr, y0;
    logic [COL_W-1:0]    nc, x0;
    logic [DXY_W-1:0]    dyoff, dx, dy;
    logic [RMOD_W-1:0]   ymod0;
    logic                emit, in_acc, cfg_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid;

    always_comb begin
        if (r_width == '0) w_eff = WID_W'(1);
        else if (r_width > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
        else w_eff = r_width;
        if (r_height == '0) h_eff = HGT_W'(1);
        else if (r_height > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
        else h_eff = r_height;
        rad_eff = (r_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
        w_m1   = w_eff - WID_W'(1);
        h_m1   = h_eff - HGT_W'(1);
        nr_sum = HGT_W'(r_orow) + HGT_W'(rad_eff);
        nc_sum = WID_W'(r_ocol) + WID_W'(rad_eff);
        nr = (nr_sum > h_m1) ? h_m1[ROW_W-1:0] : nr_sum[ROW_W-1:0];
        nc = (nc_sum > w_m1) ? w_m1[COL_W-1:0] : nc_sum[COL_W-1:0];
        y0 = (r_orow > ROW_W'(rad_eff)) ? r_orow - ROW_W'(rad_eff) : '0;
        x0 = (r_ocol > COL_W'(rad_eff)) ? r_ocol - COL_W'(rad_eff) : '0;
        dyoff = DXY_W'(r_orow - y0);
        if (r_ormod >= RMOD_W'(dyoff)) ymod0 = r_ormod - RMOD_W'(dyoff);
        else ymod0 = RMOD_W'(6'(r_ormod) + 6'(LS_ROWS) - 6'(dyoff));
        // Outputs wait until the bottom right corner of their window is in.
        emit = r_ahead || (nr < r_irow) || ((nr == r_irow) && (nc < r_icol));
        dx = (r_x >= r_ocol) ? DXY_W'(r_x - r_ocol) : DXY_W'(r_ocol - r_x);
        dy = (r_y >= r_orow) ? DXY_W'(r_y - r_orow) : DXY_W'(r_orow - r_y);
    end

    always_comb begin
        n_state = r_state;
        n_fmt = r_fmt; n_width = r_width; n_height = r_height; n_radius = r_radius;
        n_icol = r_icol; n_irow = r_irow; n_irmod = r_irmod;
        n_ocol = r_ocol; n_orow = r_orow; n_ormod = r_ormod; n_ahead = r_ahead;
        n_x = r_x; n_x0 = r_x0; n_nc = r_nc; n_y = r_y; n_nr = r_nr; n_ymod = r_ymod;
        n_dcnt = r_dcnt;

        o_cmd          = '0;
        o_cmd.fmt      = r_fmt;
        o_cmd.msel     = (w_eff < WID_W'(BT601_LIMIT));
        o_cmd.wr_addr  = LS_AW'(LS_AW'(r_irmod) * LS_AW'(MAX_WIDTH) + LS_AW'(r_icol));
        o_cmd.last     = (r_orow == h_m1[ROW_W-1:0]) && (r_ocol == w_m1[COL_W-1:0]);
        o_cmd.rd_si    = SW_AW'(8'({4'b0, dx} * {4'b0, dx}) + 8'({4'b0, dy} * {4'b0, dy}));

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.wr_en = (i_func == FUNC_PIXEL);
                    o_cmd.sw_wr = (i_func == FUNC_LOAD);
                    if (i_func == FUNC_PIXEL) begin
                        if (WID_W'(r_icol) + WID_W'(1) >= w_eff) begin
                            n_icol = '0;
                            if (HGT_W'(r_irow) + HGT_W'(1) >= h_eff) begin
                                n_irow  = '0;
                                n_irmod = '0;
                                n_ahead = 1'b1;
                            end else begin
                                n_irow  = r_irow + ROW_W'(1);
                                n_irmod = (r_irmod == RMOD_W'(LS_ROWS - 1)) ? '0
                                        : r_irmod + RMOD_W'(1);
                            end
                        end else begin
                            n_icol = r_icol + COL_W'(1);
                        end
                    end
                    if (i_func == FUNC_PIXEL || i_func == FUNC_DRAIN) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (emit) begin
                    n_nr = nr; n_nc = nc; n_x0 = x0;
                    n_x = x0; n_y = y0; n_ymod = ymod0;
                    n_state = S_REF;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REF: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_ref  = 1'b1;
                o_cmd.rd_addr = LS_AW'(LS_AW'(r_ormod) * LS_AW'(MAX_WIDTH) + LS_AW'(r_ocol));
                n_state = S_TAPS;
            end
            S_TAPS: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = LS_AW'(LS_AW'(r_ymod) * LS_AW'(MAX_WIDTH) + LS_AW'(r_x));
                if (r_x == r_nc) begin
                    n_x = r_x0;
                    if (r_y == r_nr) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_y = r_y + ROW_W'(1);
                        n_ymod = (r_ymod == RMOD_W'(LS_ROWS - 1)) ? '0 : r_ymod + RMOD_W'(1);
                    end
                end else begin
                    n_x = r_x + COL_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.div_load = 1'b1;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt = r_dcnt + DIVC_W'(1);
                if (r_dcnt == DIVC_W'(DIV_STEPS - 1)) n_state = S_CONV;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                    if (WID_W'(r_ocol) + WID_W'(1) >= w_eff) begin
                        n_ocol = '0;
                        if (HGT_W'(r_orow) + HGT_W'(1) >= h_eff) begin
                            n_orow  = '0;
                            n_ormod = '0;
                            n_ahead = 1'b0;
                        end else begin
                            n_orow  = r_orow + ROW_W'(1);
                            n_ormod = (r_ormod == RMOD_W'(LS_ROWS - 1)) ? '0
                                    : r_ormod + RMOD_W'(1);
                        end
                    end else begin
                        n_ocol = r_ocol + COL_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Geometry writes restart the frame.
        if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_FORMAT: n_fmt    = i_cfg_data[0];
                CFG_WIDTH:  n_width  = i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: n_height = i_cfg_data[HGT_W-1:0];
                CFG_RADIUS: n_radius = i_cfg_data[RAD_W-1:0];
                default:    n_fmt    = r_fmt;
            endcase
            if (i_cfg_index != CFG_FORMAT) begin
                n_icol = '0; n_irow = '0; n_irmod = '0;
                n_ocol = '0; n_orow = '0; n_ormod = '0; n_ahead = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fmt    <= 1'b0;
            r_width  <= WID_W'(1920);
            r_height <= HGT_W'(1080);
            r_radius <= RAD_W'(3);
            r_icol   <= '0; r_irow <= '0; r_irmod <= '0;
            r_ocol   <= '0; r_orow <= '0; r_ormod <= '0;
            r_ahead  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fmt    <= n_fmt;
            r_width  <= n_width;
            r_height <= n_height;
            r_radius <= n_radius;
            r_icol   <= n_icol; r_irow <= n_irow; r_irmod <= n_irmod;
            r_ocol   <= n_ocol; r_orow <= n_orow; r_ormod <= n_ormod;
            r_ahead  <= n_ahead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_x0 <= n_x0; r_nc <= n_nc;
        r_y <= n_y; r_nr <= n_nr; r_ymod <= n_ymod;
        r_dcnt <= n_dcnt;
    end

    a_tap_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAPS) |-> (r_x <= r_nc && r_y <= r_nr))
        else $error("tap outside the window");
    a_pixel_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_func == FUNC_PIXEL || i_func == FUNC_DRAIN)) |=> (r_state == S_CHECK))
        else $error("pixel or drain beat did not check for an output");
    a_div_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_load |-> !i_stat.pipe_busy)
        else $error("division started before the sums settled");
    a_row_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_irmod < RMOD_W'(LS_ROWS)) && (r_ormod < RMOD_W'(LS_ROWS)))
        else $error("line store row index out of range");
endmodule

// File: src/blf_dpath.sv
// Datapath: line store, weight tables, tap pipeline, divider and color conversion.
module blf_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blf_pkg::t_cmd        i_cmd,
    input  logic [31:0]          i_pixel_word,
    input  logic [7:0]           i_weight_index,
    input  logic [15:0]          i_weight_value,
    output blf_pkg::t_stat       o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_out_pixel,
    output logic                 o_last,
    output logic                 o_zero
);
    import blf_pkg::*;

    localparam t_rng_rom RANGE_ROM = f_range_rom();
    localparam int UV_W  = 26;
    localparam int PRD_W = 44;
    localparam int SUM_W = 46;

    logic [31:0]            ls_mem [LS_DEPTH];
    logic [WEIGHT_BITS-1:0] sw_mem [SW_DEPTH];

    logic                   r_v1, r_ref1, r_v2, r_v3, r_v4, r_v5;
    logic [31:0]            r_q1, r_refpix;
    logic [WEIGHT_BITS-1:0] r_sw1, r_sw2, r_sw3, r_rng3, r_wt4, r_wt5;
    logic [LUMA_W-1:0]      r_yq2, r_yq3, r_yq4, r_yref;
    logic [31:0]            r_prod5;
    logic [NUM_W-1:0]       r_num;
    logic [NORM_W-1:0]      r_norm;
    logic [NORM_W-1:0]      r_rem;
    logic [LUMA_W-1:0]      r_qt;
    logic signed [UV_W-1:0] r_u, r_v;
    logic signed [PRD_W-1:0] r_pr, r_pgu, r_pgv, r_pb;
    logic                   r_out_valid;
    logic [31:0]            r_out_pixel;
    logic                   r_last, r_zero;

    logic [LUMA_W-1:0]      yq1, dlum;
    logic [LUMA_W:0]        dround;
    logic [31:0]            wprod;
    logic [NORM_W:0]        trial;
    logic signed [SUM_W-1:0] yy, sr, sg, sb;
    logic [31:0]            bgra, vuya;

    function automatic logic [LUMA_W-1:0] f_luma(input logic [31:0] p, input logic fmt,
                                                 input logic msel);
        logic [15:0] cr, cg, cb;
        logic [24:0] s;
        cr = msel ? 16'd19595 : 16'd13933;
        cg = msel ? 16'd38470 : 16'd46871;
        cb = msel ? 16'd7471  : 16'd4732;
        s  = 25'(cr) * 25'(p[23:16]) + 25'(cg) * 25'(p[15:8])
           + 25'(cb) * 25'(p[7:0]) + 25'd128;
        return fmt ? s[23:8] : {p[23:16], 8'h00};
    endfunction

    function automatic logic [7:0] f_clamp8(input logic signed [SUM_W-1:0] s);
        if (s[SUM_W-1]) return 8'd0;
        if (s[SUM_W-2:32] > (SUM_W - 33)'(255)) return 8'hFF;
        return s[39:32];
    endfunction

    // Tables: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) ls_mem[i_cmd.wr_addr] <= i_pixel_word;
        if (i_cmd.rd_en) r_q1 <= ls_mem[i_cmd.rd_addr];
        if (i_cmd.sw_wr && (i_weight_index < 8'(SW_DEPTH)))
            sw_mem[i_weight_index[SW_AW-1:0]] <= i_weight_value[WEIGHT_BITS-1:0];
        if (i_cmd.rd_en) r_sw1 <= sw_mem[i_cmd.rd_si];
    end

    assign yq1    = f_luma(r_q1, i_cmd.fmt, i_cmd.msel);
    assign dlum   = (r_yq2 > r_yref) ? r_yq2 - r_yref : r_yref - r_yq2;
    assign dround = (LUMA_W + 1)'(dlum) + (LUMA_W + 1)'(128);
    assign wprod  = r_sw3 * r_rng3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_ref1 <= 1'b0;
            r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else begin
            r_v1   <= i_cmd.rd_en;
            r_ref1 <= i_cmd.rd_ref;
            r_v2   <= r_v1 && !r_ref1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_yq2  <= yq1;
        r_sw2  <= r_sw1;
        r_yq3  <= r_yq2;
        r_sw3  <= r_sw2;
        r_rng3 <= RANGE_ROM[dround[LUMA_W-1:8]];
        r_yq4  <= r_yq3;
        r_wt4  <= wprod[31:WEIGHT_BITS];
        r_wt5  <= r_wt4;
        r_prod5 <= r_wt4 * r_yq4;
        if (r_v1 && r_ref1) begin
            r_yref   <= yq1;
            r_refpix <= r_q1;
            r_num    <= '0;
            r_norm   <= '0;
        end else if (r_v5) begin
            r_num  <= r_num + NUM_W'(r_prod5);
            r_norm <= r_norm + NORM_W'(r_wt5);
        end
    end

    // Restoring divider: the mean never exceeds the largest luma, so the
    // quotient has LUMA_W bits and the top of the numerator starts the remainder.
    assign trial = {r_rem, r_qt[LUMA_W-1]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= r_num[NUM_W-1:LUMA_W];
            r_qt  <= r_num[LUMA_W-1:0];
        end else if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_norm}) begin
                r_rem <= NORM_W'(trial - {1'b0, r_norm});
                r_qt  <= {r_qt[LUMA_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[NORM_W-1:0];
                r_qt  <= {r_qt[LUMA_W-2:0], 1'b0};
            end
        end
    end

    // Chroma of the center pixel from the forward matrix, then inverse terms.
    always_ff @(posedge i_clk) begin
        if (i_cmd.msel) begin
            r_u <= UV_W'(-18'sd11058 * $signed({1'b0, r_refpix[23:16]})
                       - 18'sd21710 * $signed({1'b0, r_refpix[15:8]})
                       + 18'sd32768 * $signed({1'b0, r_refpix[7:0]}));
            r_v <= UV_W'(18'sd32768 * $signed({1'b0, r_refpix[23:16]})
                       - 18'sd27439 * $signed({1'b0, r_refpix[15:8]})
                       - 18'sd5329  * $signed({1'b0, r_refpix[7:0]}));
        end else begin
            r_u <= UV_W'(-18'sd7508  * $signed({1'b0, r_refpix[23:16]})
                       - 18'sd25260 * $signed({1'b0, r_refpix[15:8]})
                       + 18'sd32768 * $signed({1'b0, r_refpix[7:0]}));
            r_v <= UV_W'(18'sd32768 * $signed({1'b0, r_refpix[23:16]})
                       - 18'sd29763 * $signed({1'b0, r_refpix[15:8]})
                       - 18'sd3005  * $signed({1'b0, r_refpix[7:0]}));
        end
        if (i_cmd.conv) begin
            r_pr  <= PRD_W'((i_cmd.msel ? 18'sd92242  : 18'sd103206) * r_v);
            r_pgu <= PRD_W'((i_cmd.msel ? 18'sd22554  : 18'sd12277)  * r_u);
            r_pgv <= PRD_W'((i_cmd.msel ? 18'sd46983  : 18'sd30679)  * r_v);
            r_pb  <= PRD_W'((i_cmd.msel ? 18'sd116589 : 18'sd121609) * r_u);
        end
    end

    assign yy   = $signed({{(SUM_W - LUMA_W - 24){1'b0}}, r_qt, 24'd0});
    assign sr   = yy + SUM_W'(r_pr);
    assign sg   = yy - SUM_W'(r_pgu) - SUM_W'(r_pgv);
    assign sb   = yy + SUM_W'(r_pb);
    assign bgra = {r_refpix[31:24], f_clamp8(sr), f_clamp8(sg), f_clamp8(sb)};
    assign vuya = {r_refpix[31:24], r_qt[LUMA_W-1:8], r_refpix[15:0]};

    // Output register: the next pixel can be taken while this one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_zero <= (r_norm == '0);
            r_last <= i_cmd.last;
            if (r_norm == '0) r_out_pixel <= r_refpix;
            else r_out_pixel <= i_cmd.fmt ? bgra : vuya;
        end
    end

    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_last      = r_last;
    assign o_zero      = r_zero;
endmodule

// File: src/bilateral_luma_filter_top.sv
// Top level of the bilateral luma filter: controller, datapath and channels.
//
// Items enter on i_in. A pixel beat (func pixel) writes the line store and may
// release one filtered pixel; a drain beat releases a pending output without
// new data; a weight load beat writes one spatial weight, indexed by the
// squared distance of the tap. Results leave on o_out in raster order, one per
// beat, with the last flag on the bottom right pixel of the frame.
// Registers are written on i_cfg (index 0 format, 1 width, 2 height, 3 radius);
// a write of width, height or radius restarts the frame counters.
// Sequence: a weight load or unused beat is taken in the idle state alone, and a
// pixel or drain beat that releases no output passes the idle and check states.
// One that releases an output then reads the center pixel and every tap of the
// clipped window (up to 441 taps at radius 10): the line store has one read port,
// so the window is walked one tap per cycle, followed by a 5 stage weight pipeline
// and a bit-serial divider. The output register holds a finished pixel while
// the receiver stalls; the block keeps taking beats and only waits when a
// second result is ready before the first was taken.
// Reset clears the counters and sets the registers to their defaults; the
// line store and spatial table hold no data until written, so no clear is run.
module bilateral_luma_filter_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    blf_in_if.sink           i_in,
    blf_out_if.source        o_out,
    blf_cfg_if.sink          i_cfg
);
    import blf_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The sequencer owns all counters and registers; the datapath only does
    // what each command says in the cycle it is given.
    blf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (t_func'(i_in.func)),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    blf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_pixel_word   (i_in.pixel_word),
        .i_weight_index (i_in.weight_index),
        .i_weight_value (i_in.weight_value),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_pixel    (o_out.out_pixel),
        .o_last         (o_out.last_in_frame),
        .o_zero         (o_out.zero_normaliser)
    );
endmodule

// File: test/bilateral_luma_filter_top_tb.sv
// Self-checking testbench of the bilateral luma filter top level.
`timescale 1ns / 100ps

module bilateral_luma_filter_top_tb;

    import blf_pkg::*;

    // The run stops here even if the block hangs; the slowest legal run is far below it.
    localparam int CYCLE_LIMIT = 4000000;
    // Cycles granted to the block after the last result before a register write
    // or the end: one full radius 10 window plus the weight pipe and the divider.
    localparam int SETTLE_CYCLES = 600;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PIXELS = 350;
    // Pixels sent at the start of each frame at the geometry extremes.
    localparam int EDGE_PIXELS = 24;

    typedef struct {
        t_func       func;
        logic [31:0] pixel_word;
        logic [7:0]  weight_index;
        logic [15:0] weight_value;
    } pix_beat_t;

    typedef struct {
        logic [31:0] out_pixel;
        logic        last_in_frame;
        logic        zero_normaliser;
    } filtered_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    blf_in_if  in_ch ();
    blf_out_if out_ch ();
    blf_cfg_if cfg_ch ();

    bilateral_luma_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // Beats waiting to be driven and filtered pixels waiting to be seen.
    pix_beat_t beat_q[$];
    filtered_t filtered_q[$];

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        hold_rx = 1'b0;
    logic        hold_go = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------
    // Filter predictor: its own copy of the registers, the line store,
    // the spatial weight table and the raster counters.
    // ------------------------------------------------------------------
    logic        fmt_m;
    int unsigned wid_m, hgt_m, rad_m;
    logic [31:0] line_mem [LS_ROWS*MAX_WIDTH];
    logic [15:0] sw_tab [SW_DEPTH];
    logic [15:0] rng_tab [256];
    int unsigned in_col, in_row, out_col, out_row;
    logic        frame_ahead;

    // Forward matrix (Y, U, V rows) and inverse magnitudes (Vr, Ug, Vg, Ub),
    // row 0 BT.601, row 1 BT.709; the forward terms in signed Q0.16, the inverse in Q1.16.
    longint fwd_k [0:1][0:8] = '{
        '{19595, 38470, 7471, -11058, -21710, 32768, 32768, -27439, -5329},
        '{13933, 46871, 4732, -7508, -25260, 32768, 32768, -29763, -3005}
    };
    longint inv_k [0:1][0:3] = '{
        '{92242, 22554, 46983, 116589},
        '{103206, 12277, 30679, 121609}
    };

    // Range weights follow a fixed point exponential recurrence, rounded to Q0.16.
    task automatic build_range_table();
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] q2;
        logic [63:0] v;
        e  = 64'h1_0000_0000;
        m  = 64'd4291666015;
        q2 = (m * m) >> 32;
        for (int d = 0; d < 256; d++) begin
            if (d > 0) begin
                e = (e * m) >> 32;
                m = (m * q2) >> 32;
            end
            v = (e + (64'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
            rng_tab[d] = (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
        end
    endtask

    function automatic int mat_sel();
        return (wid_m < BT601_LIMIT) ? 0 : 1;
    endfunction

    // Luma in Q8.8 of a packed pixel in the current format.
    function automatic logic [31:0] luma_of(logic [31:0] p);
        longint s;
        int     k;
        if (fmt_m == 1'b0) return {16'h0, p[23:16], 8'h0};
        k = mat_sel();
        s = fwd_k[k][0] * longint'(p[23:16]) + fwd_k[k][1] * longint'(p[15:8])
            + fwd_k[k][2] * longint'(p[7:0]) + 128;
        return 32'(s >>> 8);
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        longint t;
        if (v < 0) return 8'd0;
        t = v >>> 32;
        return (t > 255) ? 8'd255 : 8'(t);
    endfunction

    // Releases the next output in raster order once its clipped window is complete.
    task automatic release_output();
        int unsigned nr, nc, y0, x0, dy, dx, si, d;
        logic [31:0] ref_px, yref, yq;
        logic [63:0] norm, num, wt, yf;
        longint      u, v, yy;
        int          k;
        filtered_t   res;
        nr = (out_row + rad_m > hgt_m - 1) ? hgt_m - 1 : out_row + rad_m;
        nc = (out_col + rad_m > wid_m - 1) ? wid_m - 1 : out_col + rad_m;
        y0 = (out_row > rad_m) ? out_row - rad_m : 0;
        x0 = (out_col > rad_m) ? out_col - rad_m : 0;
        if (!frame_ahead && nr * wid_m + nc >= in_row * wid_m + in_col) return;
        ref_px = line_mem[(out_row % LS_ROWS) * MAX_WIDTH + out_col];
        yref = luma_of(ref_px);
        norm = 0;
        num = 0;
        for (int unsigned y = y0; y <= nr; y++) begin
            for (int unsigned x = x0; x <= nc; x++) begin
                yq = luma_of(line_mem[(y % LS_ROWS) * MAX_WIDTH + x]);
                d  = (yq > yref) ? yq - yref : yref - yq;
                dy = (y > out_row) ? y - out_row : out_row - y;
                dx = (x > out_col) ? x - out_col : out_col - x;
                si = dx * dx + dy * dy;
                wt = (64'(sw_tab[si]) * 64'(rng_tab[((d + 128) >> 8) & 255])) >> WEIGHT_BITS;
                norm += wt;
                num  += wt * 64'(yq);
            end
        end
        res.zero_normaliser = (norm == 0);
        res.last_in_frame = (out_row == hgt_m - 1) && (out_col == wid_m - 1);
        if (norm == 0) begin
            res.out_pixel = ref_px;
        end else begin
            yf = num / norm;
            if (fmt_m == 1'b0) begin
                res.out_pixel = (ref_px & 32'hFF00FFFF) | {8'h0, yf[15:8], 16'h0};
            end else begin
                k  = mat_sel();
                u  = fwd_k[k][3] * longint'(ref_px[23:16]) + fwd_k[k][4] * longint'(ref_px[15:8])
                     + fwd_k[k][5] * longint'(ref_px[7:0]);
                v  = fwd_k[k][6] * longint'(ref_px[23:16]) + fwd_k[k][7] * longint'(ref_px[15:8])
                     + fwd_k[k][8] * longint'(ref_px[7:0]);
                yy = longint'(yf) * 16777216;
                res.out_pixel = {ref_px[31:24], clamp_byte(yy + inv_k[k][0] * v),
                                 clamp_byte(yy - inv_k[k][1] * u - inv_k[k][2] * v),
                                 clamp_byte(yy + inv_k[k][3] * u)};
            end
        end
        filtered_q.push_back(res);
        out_col++;
        if (out_col >= wid_m) begin
            out_col = 0;
            out_row++;
            if (out_row >= hgt_m) begin
                out_row = 0;
                frame_ahead = 1'b0;
            end
        end
    endtask

    // Queues one beat for the driver and advances the predictor by it.
    task automatic push_beat(pix_beat_t b);
        beat_q.push_back(b);
        case (b.func)
            FUNC_LOAD: begin
                if (b.weight_index < SW_DEPTH) sw_tab[b.weight_index] = b.weight_value;
            end
            FUNC_PIXEL: begin
                line_mem[(in_row % LS_ROWS) * MAX_WIDTH + in_col] = b.pixel_word;
                in_col++;
                if (in_col >= wid_m) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= hgt_m) begin
                        in_row = 0;
                        frame_ahead = 1'b1;
                    end
                end
                release_output();
            end
            FUNC_DRAIN: release_output();
            default: ;
        endcase
    endtask

    task automatic push_func(t_func f, logic [31:0] px, logic [7:0] idx, logic [15:0] val);
        pix_beat_t b;
        b.func = f;
        b.pixel_word = px;
        b.weight_index = idx;
        b.weight_value = val;
        push_beat(b);
    endtask

    // A beat that carries no pixel: a drain, which may release a pending output, a
    // reserved function, an out of range load or an in range load that changes the table.
    task automatic push_noise();
        case ($urandom_range(0, 3))
            0: push_func(FUNC_DRAIN, $urandom, $urandom, $urandom);
            1: push_func(FUNC_NONE, $urandom, $urandom, $urandom);
            2: push_func(FUNC_LOAD, $urandom, $urandom_range(SW_DEPTH, 255), $urandom);
            default: push_func(FUNC_LOAD, $urandom, $urandom_range(0, SW_DEPTH - 1), $urandom);
        endcase
    endtask

    // One whole frame of pixels, optionally mixed with noise beats, then
    // drain beats until every pending output has been released.
    task automatic push_frame(int unsigned noise_pct);
        logic [31:0] base;
        logic [31:0] px;
        logic        smooth;
        base = $urandom;
        smooth = $urandom_range(0, 1);
        for (int unsigned n = 0; n < wid_m * hgt_m; n++) begin
            if ($urandom_range(0, 99) < noise_pct) push_noise();
            if (smooth && $urandom_range(0, 7) != 0) begin
                px = $urandom;
                for (int i = 0; i < 4; i++) px[8*i +: 8] = base[8*i +: 8] + px[8*i +: 4];
            end else begin
                px = $urandom;
            end
            push_func(FUNC_PIXEL, px, $urandom, $urandom);
        end
        while (frame_ahead) push_func(FUNC_DRAIN, $urandom, $urandom, $urandom);
    endtask

    // The first pixels of a frame only; the next width, height or radius write drops the rest.
    task automatic push_partial(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            push_func(FUNC_PIXEL, $urandom, $urandom, $urandom);
    endtask

    // Returns once the block has taken every beat and returned every result.
    task automatic wait_idle();
        while (beat_q.size() != 0 || in_ch.valid || filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write on the configuration channel, mirrored in the predictor.
    task automatic write_reg(t_cfg_idx idx, int unsigned val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DW'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FORMAT: fmt_m = val[0];
            CFG_WIDTH:  wid_m = val;
            CFG_HEIGHT: hgt_m = val;
            CFG_RADIUS: rad_m = val;
            default: ;
        endcase
        if (idx != CFG_FORMAT) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            frame_ahead = 1'b0;
        end
    endtask

    task automatic set_geometry(logic f, int unsigned w, int unsigned h, int unsigned r);
        wait_idle();
        write_reg(CFG_FORMAT, f);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_RADIUS, r);
    endtask

    // Idling patterns: none, sender gaps, receiver stalls, both.
    task automatic set_idling(int unsigned mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: holds each beat until it is accepted, then either offers the
    // next one or idles. valid is assigned once per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) void'(beat_q.pop_front());
            if (!in_ch.valid || in_ch.ready) begin
                if (beat_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_ch.valid        <= 1'b1;
                    in_ch.func         <= beat_q[0].func;
                    in_ch.pixel_word   <= beat_q[0].pixel_word;
                    in_ch.weight_index <= beat_q[0].weight_index;
                    in_ch.weight_value <= beat_q[0].weight_value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, and a forced hold-off while hold_rx is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: every accepted result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (filtered_q.size() == 0) begin
                $error("result beat with no prediction waiting: out_pixel %h", out_ch.out_pixel);
                fail_count++;
            end else begin
                if (out_ch.out_pixel !== filtered_q[0].out_pixel) begin
                    $error("out_pixel: expected %h, actual %h",
                           filtered_q[0].out_pixel, out_ch.out_pixel);
                    fail_count++;
                end
                if (out_ch.last_in_frame !== filtered_q[0].last_in_frame) begin
                    $error("last_in_frame: expected %b, actual %b",
                           filtered_q[0].last_in_frame, out_ch.last_in_frame);
                    fail_count++;
                end
                if (out_ch.zero_normaliser !== filtered_q[0].zero_normaliser) begin
                    $error("zero_normaliser: expected %b, actual %b",
                           filtered_q[0].zero_normaliser, out_ch.zero_normaliser);
                    fail_count++;
                end
                void'(filtered_q.pop_front());
            end
        end
    end

    // Long receiver hold-off, counted in its own process, so that the block
    // backs up and stalls its input while the driver keeps offering beats.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bilateral_luma_filter_top_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial begin
        int unsigned pixels_sent;
        int unsigned phase;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_FORMAT;
        cfg_ch.data        = '0;

        build_range_table();
        fmt_m = 1'b0;
        wid_m = 1920;
        hgt_m = 1080;
        rad_m = 3;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_ahead = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small geometry first, then fill the whole spatial table so that no
        // window ever reads an entry that was never loaded. Entry 0 takes the
        // largest weight and the outermost entry a random one.
        set_geometry(1'b0, 3, 3, 1);
        push_func(FUNC_LOAD, $urandom, 8'd0, 16'hFFFF);
        for (int i = 1; i < SW_DEPTH; i++)
            push_func(FUNC_LOAD, $urandom, 8'(i), 16'($urandom_range(1, 65535)));

        // Directed part: pixel extremes in both formats, the reserved function,
        // an ignored out of range load, idle drains and a 1x1 frame whose only
        // tap has zero spatial weight, which forces the pass-through case.
        push_func(FUNC_DRAIN, 32'h0, 8'h0, 16'h0);
        push_func(FUNC_NONE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        push_func(FUNC_LOAD, 32'h0, 8'hFF, 16'h0000);
        for (int i = 0; i < 9; i++)
            push_func(FUNC_PIXEL, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 8'h0, 16'h0);
        while (frame_ahead) push_func(FUNC_DRAIN, 32'h0, 8'h0, 16'h0);
        set_geometry(1'b1, 3, 3, 1);
        for (int i = 0; i < 9; i++)
            push_func(FUNC_PIXEL, (i % 3 == 0) ? 32'hFFFF_FFFF : 32'($urandom), 8'h0, 16'h0);
        while (frame_ahead) push_func(FUNC_DRAIN, 32'h0, 8'h0, 16'h0);
        set_geometry(1'b0, 1, 1, 1);
        push_func(FUNC_LOAD, 32'h0, 8'd0, 16'h0000);
        push_func(FUNC_PIXEL, 32'h12345678, 8'h0, 16'h0);
        push_func(FUNC_LOAD, 32'h0, 8'd0, 16'hFFFF);

        // Random part: small random frames in rotating idling patterns, with
        // noise beats mixed in. The third phase carries the long hold-off.
        pixels_sent = 0;
        phase = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            set_geometry($urandom_range(0, 1), $urandom_range(1, 16),
                         $urandom_range(1, 8), $urandom_range(1, MAX_RADIUS));
            set_idling(phase);
            push_frame(15);
            if (phase == 2) hold_go = 1'b1;
            pixels_sent += wid_m * hgt_m;
            phase++;
        end

        // The first pixels of frames at the geometry extremes and on both sides
        // of the matrix switch at width 800, without idling.
        set_idling(0);
        set_geometry(1'b0, MAX_WIDTH, 1, MAX_RADIUS);
        push_partial(EDGE_PIXELS);
        set_geometry(1'b1, 1, MAX_HEIGHT, 1);
        push_partial(EDGE_PIXELS);
        set_geometry(1'b1, BT601_LIMIT - 1, 1, 2);
        push_partial(EDGE_PIXELS);
        set_geometry(1'b1, BT601_LIMIT, 1, 2);
        push_partial(EDGE_PIXELS);

        wait_idle();
        if (fail_count == 0) begin
            $display("bilateral_luma_filter_top_tb passed");
        end else begin
            $display("bilateral_luma_filter_top_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/blf_pkg.sv
src/blf_in_if.sv
src/blf_out_if.sv
src/blf_cfg_if.sv
src/blf_ctrl.sv
src/blf_dpath.sv
src/bilateral_luma_filter_top.sv
test/bilateral_luma_filter_top_tb.sv
